>>> hw/rtl/stb_pkg.sv
`timescale 1ns / 1ps
package stb_pkg;

  localparam logic [2:0] FUNC_CREATE = 3'd0;
  localparam logic [2:0] FUNC_START  = 3'd1;
  localparam logic [2:0] FUNC_STOP   = 3'd2;
  localparam logic [2:0] FUNC_DELETE = 3'd3;
  localparam logic [2:0] FUNC_QUERY  = 3'd4;
  localparam logic [2:0] FUNC_TICK   = 3'd5;

  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_BAD_ID      = 3'd1;
  localparam logic [2:0] STS_NOT_CREATED = 3'd2;
  localparam logic [2:0] STS_NOT_STARTED = 3'd3;
  localparam logic [2:0] STS_ZERO_IVAL   = 3'd4;
  localparam logic [2:0] STS_BAD_MODE    = 3'd5;
  localparam logic [2:0] STS_NONE_FREE   = 3'd6;

  localparam logic [1:0] SLOT_UNUSED  = 2'd0;
  localparam logic [1:0] SLOT_CREATED = 2'd1;
  localparam logic [1:0] SLOT_TICKING = 2'd2;

  localparam logic [1:0] MODE_ONESHOT  = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_NO_SDEL  = 2'd2;

  typedef struct packed {
    logic [15:0] tag;
    logic [1:0]  status;
    logic [1:0]  mode;
    logic [31:0] reload;
    logic [31:0] left;
  } slot_t;

endpackage

>>> hw/rtl/stb_slot_ram.sv
`timescale 1ns / 1ps
module stb_slot_ram import stb_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int SW = $clog2(SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [SW-1:0] raddr_i,
  output slot_t         rdata_o,
  input  logic          we_i,
  input  logic [SW-1:0] waddr_i,
  input  slot_t         wdata_i
);

  slot_t             mem [SLOTS];
  logic [SLOTS-1:0]  vld_q;
  slot_t             rdata_q;
  logic              rvld_q;
  logic [SW-1:0]     raddr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[raddr_i];
      raddr_q <= raddr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  // never-written entries read as their reset value
  always_comb begin
    if (rvld_q) begin
      rdata_o = rdata_q;
    end else begin
      rdata_o        = '0;
      rdata_o.tag    = 16'(raddr_q);
      rdata_o.status = SLOT_UNUSED;
    end
  end

endmodule

>>> hw/rtl/stb_free_list.sv
`timescale 1ns / 1ps
module stb_free_list import stb_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int SW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  output logic [SW-1:0] rdata_o,
  input  logic          pop_i,
  input  logic          push_i,
  input  logic [SW-1:0] push_slot_i,
  output logic          empty_o,
  output logic [CW-1:0] count_o
);

  logic [SW-1:0]    mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [SW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [SW-1:0]    rdata_q, raddr_q;
  logic             rvld_q;
  logic [CW:0]      tail_sum;
  logic [SW-1:0]    tail;
  logic             do_push;

  assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
  assign tail     = (tail_sum >= (CW+1)'(SLOTS)) ? SW'(tail_sum - (CW+1)'(SLOTS))
                                                 : SW'(tail_sum);
  assign do_push  = push_i && (count_q < CW'(SLOTS));

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (pop_i) begin
      head_d  = (head_q == SW'(SLOTS - 1)) ? '0 : head_q + SW'(1);
      count_d = count_q - CW'(1);
    end else if (do_push) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail] <= push_slot_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[head_q];
      raddr_q <= head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      head_q  <= '0;
      count_q <= CW'(SLOTS);
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (do_push) begin
        vld_q[tail] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[head_q];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : raddr_q;
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

>>> hw/rtl/software_timer_bank.sv
`timescale 1ns / 1ps
// Bank of TIMER_SLOTS software timers kept in a slot RAM and a free-list RAM,
// both with registered reads. One command is handled at a time; in_stall_o
// is high after the accepting cycle until the last result is loaded into the
// output register. Create reads a free slot from the free list, then the slot
// RAM, then writes the slot and pops the free list. For start, stop, delete and
// query the id is reduced to its slot index by a reciprocal multiply at accept
// and one compare and subtract. A tick walks the slot RAM one slot per cycle,
// pausing while an expiry is waiting on a stalled output. Both RAMs come out of
// reset ready, with no clearing pass.
module software_timer_bank import stb_pkg::*; #(
  parameter int TIMER_SLOTS = 16,
  parameter int ID_LIMIT    = 65520
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] timer_id_i,
  input  logic [31:0] interval_i,
  input  logic [1:0]  mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] result_id_o,
  output logic [31:0] remaining_o,
  output logic        expired_o,
  output logic        last_o
);

  localparam int SW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [31:0] ID_RECIP = 32'((64'd1 << 32) / TIMER_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_CR_FL, S_CR_SL, S_MOD, S_CMD, S_TICK, S_TEND, S_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [2:0]    func_q, func_d;
  logic [15:0]   id_q, id_d;
  logic [31:0]   ival_q, ival_d;
  logic [1:0]    mode_q, mode_d;
  logic [15:0]   quot_q, quot_d;
  logic [SW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [15:0]   pend_id_q, pend_id_d;
  logic [2:0]    res_sts_q, res_sts_d;
  logic [15:0]   res_id_q, res_id_d;
  logic [31:0]   res_rem_q, res_rem_d;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_sts_q, out_sts_d;
  logic [15:0]   out_id_q, out_id_d;
  logic [31:0]   out_rem_q, out_rem_d;
  logic          out_exp_q, out_exp_d;
  logic          out_last_q, out_last_d;

  logic          sr_rd, sr_we;
  logic [SW-1:0] sr_raddr, sr_waddr;
  slot_t         sr_rdata, sr_wdata;
  logic          fl_rd, fl_pop, fl_push, fl_empty;
  logic [SW-1:0] fl_rdata, fl_push_slot;
  logic [CW-1:0] fl_count;

  logic          out_free;
  logic [47:0]   id_prod;
  logic [16:0]   id_mod_raw;
  logic [SW-1:0] slot_sel;
  logic [31:0]   left_dec;
  logic          hit, hold;
  logic [16:0]   tag_sum;

  stb_slot_ram #(.SLOTS(TIMER_SLOTS)) u_slot_ram (
    .clk_i, .rst_ni,
    .rd_en_i (sr_rd),
    .raddr_i (sr_raddr),
    .rdata_o (sr_rdata),
    .we_i    (sr_we),
    .waddr_i (sr_waddr),
    .wdata_i (sr_wdata)
  );

  stb_free_list #(.SLOTS(TIMER_SLOTS)) u_free_list (
    .clk_i, .rst_ni,
    .rd_en_i     (fl_rd),
    .rdata_o     (fl_rdata),
    .pop_i       (fl_pop),
    .push_i      (fl_push),
    .push_slot_i (fl_push_slot),
    .empty_o     (fl_empty),
    .count_o     (fl_count)
  );

  // quotient estimate is exact or one low
  assign out_free   = !out_valid_q || !out_stall_i;
  assign id_prod    = 48'(timer_id_i) * 48'(ID_RECIP);
  assign id_mod_raw = 17'(id_q) - 17'(quot_q) * 17'(TIMER_SLOTS);
  assign slot_sel   = (id_mod_raw >= 17'(TIMER_SLOTS)) ?
                      SW'(id_mod_raw - 17'(TIMER_SLOTS)) : SW'(id_mod_raw);
  assign left_dec   = (sr_rdata.left != '0) ? sr_rdata.left - 32'd1 : sr_rdata.left;
  assign hit        = (sr_rdata.status == SLOT_TICKING) && (left_dec == '0);
  assign hold       = hit && pend_q && !out_free;
  assign tag_sum    = {1'b0, sr_rdata.tag} + 17'(TIMER_SLOTS);

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    id_d         = id_q;
    ival_d       = ival_q;
    mode_d       = mode_q;
    quot_d       = quot_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_id_d    = pend_id_q;
    res_sts_d    = res_sts_q;
    res_id_d     = res_id_q;
    res_rem_d    = res_rem_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_sts_d    = out_sts_q;
    out_id_d     = out_id_q;
    out_rem_d    = out_rem_q;
    out_exp_d    = out_exp_q;
    out_last_d   = out_last_q;
    sr_rd        = 1'b0;
    sr_raddr     = idx_q;
    sr_we        = 1'b0;
    sr_waddr     = idx_q;
    sr_wdata     = sr_rdata;
    fl_rd        = 1'b0;
    fl_pop       = 1'b0;
    fl_push      = 1'b0;
    fl_push_slot = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d    = func_i;
          id_d      = timer_id_i;
          ival_d    = interval_i;
          mode_d    = mode_i;
          res_sts_d = STS_OK;
          res_id_d  = '0;
          res_rem_d = '0;
          state_d   = S_EMIT;
          if (func_i == FUNC_CREATE) begin
            if (interval_i == '0) begin
              res_sts_d = STS_ZERO_IVAL;
            end else if (mode_i > MODE_NO_SDEL) begin
              res_sts_d = STS_BAD_MODE;
            end else if (fl_empty) begin
              res_sts_d = STS_NONE_FREE;
            end else begin
              fl_rd   = 1'b1;
              state_d = S_CR_FL;
            end
          end else if (func_i inside {[FUNC_START:FUNC_QUERY]}) begin
            if (32'(timer_id_i) >= 32'(ID_LIMIT)) begin
              res_sts_d = STS_BAD_ID;
            end else begin
              quot_d  = id_prod[47:32];
              state_d = S_MOD;
            end
          end else if (func_i == FUNC_TICK) begin
            sr_rd    = 1'b1;
            sr_raddr = '0;
            idx_d    = '0;
            pend_d   = 1'b0;
            state_d  = S_TICK;
          end
        end
      end
      S_CR_FL: begin
        sr_rd    = 1'b1;
        sr_raddr = fl_rdata;
        idx_d    = fl_rdata;
        state_d  = S_CR_SL;
      end
      S_CR_SL: begin
        sr_we           = 1'b1;
        sr_wdata.status = SLOT_CREATED;
        sr_wdata.mode   = mode_q;
        sr_wdata.reload = ival_q;
        sr_wdata.left   = '0;
        fl_pop          = 1'b1;
        res_id_d        = sr_rdata.tag;
        state_d         = S_EMIT;
      end
      S_MOD: begin
        sr_rd    = 1'b1;
        sr_raddr = slot_sel;
        idx_d    = slot_sel;
        state_d  = S_CMD;
      end
      S_CMD: begin
        state_d = S_EMIT;
        if (sr_rdata.tag != id_q) begin
          res_sts_d = STS_BAD_ID;
        end else if (!(sr_rdata.status == SLOT_CREATED ||
                       sr_rdata.status == SLOT_TICKING)) begin
          res_sts_d = STS_NOT_CREATED;
        end else begin
          case (func_q)
            FUNC_START: begin
              sr_we           = 1'b1;
              sr_wdata.left   = sr_rdata.reload;
              sr_wdata.status = SLOT_TICKING;
            end
            FUNC_STOP: begin
              if (sr_rdata.status != SLOT_TICKING) begin
                res_sts_d = STS_NOT_STARTED;
              end else begin
                sr_we           = 1'b1;
                sr_wdata.status = SLOT_CREATED;
                sr_wdata.left   = '0;
              end
            end
            FUNC_DELETE: begin
              sr_we           = 1'b1;
              sr_wdata.status = SLOT_UNUSED;
              sr_wdata.left   = '0;
              fl_push         = 1'b1;
            end
            FUNC_QUERY: begin
              if (sr_rdata.status != SLOT_TICKING) begin
                res_sts_d = STS_NOT_STARTED;
              end else begin
                res_rem_d = sr_rdata.left;
              end
            end
            default: begin
              res_sts_d = STS_OK;
            end
          endcase
        end
      end
      S_TICK: begin
        if (!hold) begin
          if (sr_rdata.status == SLOT_TICKING) begin
            sr_we         = 1'b1;
            sr_wdata.left = left_dec;
          end
          if (hit) begin
            // previous expiry goes out now, this one is held until the next hit or the end of the walk
            if (pend_q) begin
              out_valid_d = 1'b1;
              out_sts_d   = STS_OK;
              out_id_d    = pend_id_q;
              out_rem_d   = '0;
              out_exp_d   = 1'b1;
              out_last_d  = 1'b0;
            end
            pend_d    = 1'b1;
            pend_id_d = sr_rdata.tag;
            case (sr_rdata.mode)
              MODE_ONESHOT: begin
                sr_wdata.status = SLOT_UNUSED;
                sr_wdata.tag    = (tag_sum < 17'(ID_LIMIT)) ? tag_sum[15:0] : 16'(idx_q);
                fl_push         = 1'b1;
              end
              MODE_NO_SDEL: begin
                sr_wdata.status = SLOT_CREATED;
              end
              default: begin
                sr_wdata.left = sr_rdata.reload;
              end
            endcase
          end
          if (idx_q == SW'(TIMER_SLOTS - 1)) begin
            state_d = S_TEND;
          end else begin
            idx_d    = idx_q + SW'(1);
            sr_rd    = 1'b1;
            sr_raddr = idx_q + SW'(1);
          end
        end
      end
      S_TEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sts_d   = STS_OK;
          out_id_d    = pend_q ? pend_id_q : '0;
          out_rem_d   = '0;
          out_exp_d   = pend_q;
          out_last_d  = 1'b1;
          pend_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sts_d   = res_sts_q;
          out_id_d    = res_id_q;
          out_rem_d   = res_rem_q;
          out_exp_d   = 1'b0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      func_q      <= '0;
      id_q        <= '0;
      ival_q      <= '0;
      mode_q      <= '0;
      quot_q      <= '0;
      idx_q       <= '0;
      pend_id_q   <= '0;
      res_sts_q   <= '0;
      res_id_q    <= '0;
      res_rem_q   <= '0;
      out_sts_q   <= '0;
      out_id_q    <= '0;
      out_rem_q   <= '0;
      out_exp_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      func_q      <= func_d;
      id_q        <= id_d;
      ival_q      <= ival_d;
      mode_q      <= mode_d;
      quot_q      <= quot_d;
      idx_q       <= idx_d;
      pend_id_q   <= pend_id_d;
      res_sts_q   <= res_sts_d;
      res_id_q    <= res_id_d;
      res_rem_q   <= res_rem_d;
      out_sts_q   <= out_sts_d;
      out_id_q    <= out_id_d;
      out_rem_q   <= out_rem_d;
      out_exp_q   <= out_exp_d;
      out_last_q  <= out_last_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_sts_q;
  assign result_id_o = out_id_q;
  assign remaining_o = out_rem_q;
  assign expired_o   = out_exp_q;
  assign last_o      = out_last_q;

  a_free_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fl_count) <= 32'(TIMER_SLOTS))
    else $error("free count above slot count");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !pend_q)
    else $error("pending expiry left while idle");

  a_expiry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && expired_o) |-> (status_o == STS_OK))
    else $error("expiry with nonzero status");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("new transfer taken before result delivered");

endmodule
